FILE: sv/dedupe_hash_set_fifo_evict_unit_macros.svh
// Assertion helpers used by dedupe_hash_set_fifo_evict_unit.sv.
`ifndef DEDUPE_HASH_SET_FIFO_EVICT_UNIT_MACROS_SVH
`define DEDUPE_HASH_SET_FIFO_EVICT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DHSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DHSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DHSF_ASSERT_IMP(lbl, ante, cons, msg)
`define DHSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/dhsf_pkg.sv
package dhsf_pkg;

    localparam int DEF_KEY_BITS       = 32;
    localparam int DEF_MAX_SLOTS_LOG2 = 10;
    localparam int QUEUE_LOG2         = 10;
    localparam int ENTRY_W            = 10;
    localparam int LG_CFG_W           = 4;
    localparam int OUT_W              = 16;

    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_REMEMBER = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic REG_SLOT_LOG2 = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    localparam logic [LG_CFG_W-1:0] RST_SLOT_LOG2 = 4'd10;
    localparam logic [ENTRY_W-1:0]  RST_CAPACITY  = 10'd512;

endpackage

FILE: sv/dhsf_ram.sv
module dhsf_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

FILE: sv/dedupe_hash_set_fifo_evict_unit.sv
// Deduplication set of nonzero hash keys with oldest-first eviction.
// Input stream (s_*): tuser carries the opcode (lookup, remember, clear), tdata the key.
// Output stream (m_*): one response per request with present, stored, evicted,
// recovered and the live entry count.
// APB port: register 0 at address 0 is slot_count_log2, register 1 at address 4 is
// entry_capacity; any write empties the set.
// One request is worked at a time; s_tready is high only while the sequencer is idle
// and no register write lands in the same cycle.
// A lookup probes one slot at a time on the single slot-memory port. A remember
// adds an insert probe and, at capacity, a queue read per entry tried, a probe for
// the oldest key and a backward-shift walk over the slots moved past.
// A clear request, a recovery and every register write sweep the whole slot memory,
// one entry per cycle, all 2**MAX_SLOTS_LOG2 entries (1024 by default).
// After reset the same sweep runs before the first request is taken.
// The response sits in an output register; if the receiver stalls, hold it there
// and accept the next request, which waits in its response state until the
// register frees up.
`include "dedupe_hash_set_fifo_evict_unit_macros.svh"
module dedupe_hash_set_fifo_evict_unit
    import dhsf_pkg::*;
#(
    parameter int KEY_BITS       = DEF_KEY_BITS,
    parameter int MAX_SLOTS_LOG2 = DEF_MAX_SLOTS_LOG2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key in the low KEY_BITS bits, zero padding above
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0] s_tdata,
    // opcode
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // present [0], stored [1], evicted [2], recovered [3], entries [13:4], zero [15:14]
    output logic [OUT_W-1:0]                    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int SLOT_W = MAX_SLOTS_LOG2;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int LG_W   = $clog2(MAX_SLOTS_LOG2 + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_Q_RD, ST_Q_CHK, ST_DEL_WR,
        ST_SH_RD, ST_SH_CHK, ST_SH_MV, ST_INS_RD, ST_INS_CHK, ST_RESP
    } state_t;

    state_t                state_reg;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   tgt_reg;
    logic [SLOT_W-1:0]     probe_reg;
    logic [SLOT_W-1:0]     gap_reg;
    logic [SLOT_W-1:0]     scan_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ENTRY_W-1:0]    tries_reg;
    logic [QUEUE_LOG2-1:0] head_reg;
    logic [QUEUE_LOG2-1:0] tail_reg;
    logic [ENTRY_W-1:0]    live_reg;
    logic [SLOT_W-1:0]     clr_reg;
    logic                  ctx_reg;
    logic                  ins_pend_reg;
    logic                  res_pend_reg;
    logic                  present_reg;
    logic                  stored_reg;
    logic                  evicted_reg;
    logic                  recovered_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic [LG_CFG_W-1:0]   lg_cfg_reg;
    logic [ENTRY_W-1:0]    cap_cfg_reg;

    logic [LG_W-1:0]       lg_eff;
    logic [CNT_W-1:0]      n_slots;
    logic [SLOT_W-1:0]     mask;
    logic [ENTRY_W-1:0]    cap;
    logic                  cfg_wr;
    logic                  resp_fire;

    logic                  slot_en, slot_we;
    logic [SLOT_W-1:0]     slot_addr;
    logic [KEY_BITS-1:0]   slot_wdata, slot_rdata;
    logic                  q_en, q_we;
    logic [QUEUE_LOG2-1:0] q_addr;
    logic [KEY_BITS-1:0]   q_rdata;

    logic [SLOT_W-1:0]     nat;
    logic [SLOT_W-1:0]     dist_gap, dist_scan;
    logic                  sh_stop, sh_move;
    logic [ENTRY_W-1:0]    tries_inc;
    logic [QUEUE_LOG2-1:0] head_inc;
    logic [QUEUE_LOG2-1:0] tail_inc;

    function automatic logic [SLOT_W-1:0] home_of(input logic [KEY_BITS-1:0] k,
                                                  input logic [SLOT_W-1:0] m);
        logic [15:0] h;
        h = {k[KEY_BITS-9 -: 8], k[KEY_BITS-1 -: 8]};
        return h[SLOT_W-1:0] & m;
    endfunction

    // Effective geometry from the registers.
    always_comb
    begin
        if (lg_cfg_reg < 1)
        begin
            lg_eff = LG_W'(1);
        end
        else if (32'(lg_cfg_reg) > MAX_SLOTS_LOG2)
        begin
            lg_eff = LG_W'(MAX_SLOTS_LOG2);
        end
        else
        begin
            lg_eff = LG_W'(lg_cfg_reg);
        end
        n_slots = CNT_W'(1) << lg_eff;
        mask    = SLOT_W'(n_slots - CNT_W'(1));
        if (17'(cap_cfg_reg) >= 17'(n_slots))
        begin
            cap = ENTRY_W'(n_slots - CNT_W'(1));
        end
        else
        begin
            cap = cap_cfg_reg;
        end
    end

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CAPACITY) ? {22'd0, cap_cfg_reg} : {28'd0, lg_cfg_reg};
    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Launch the response when the output register is free or draining.
    assign resp_fire = (state_reg == ST_RESP) && !cfg_wr && (!m_tvalid_reg || m_tready);

    // Backward-shift test for the slot just read.
    assign nat       = home_of(slot_rdata, mask);
    assign dist_gap  = (gap_reg - nat) & mask;
    assign dist_scan = (scan_reg - nat) & mask;
    assign sh_stop   = (cnt_reg == n_slots) || (slot_rdata == '0);
    assign sh_move   = !sh_stop && (dist_gap <= dist_scan);
    assign tries_inc = tries_reg + ENTRY_W'(1);
    assign head_inc  = (head_reg + QUEUE_LOG2'(1) == QUEUE_LOG2'(cap)) ? '0
                       : head_reg + QUEUE_LOG2'(1);
    assign tail_inc  = (tail_reg + QUEUE_LOG2'(1) == QUEUE_LOG2'(cap)) ? '0
                       : tail_reg + QUEUE_LOG2'(1);

    // Memory port control.
    always_comb
    begin
        slot_en    = 1'b0;
        slot_we    = 1'b0;
        slot_addr  = probe_reg;
        slot_wdata = '0;
        q_en       = 1'b0;
        q_we       = 1'b0;
        q_addr     = head_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                slot_en   = 1'b1;
                slot_we   = 1'b1;
                slot_addr = clr_reg;
            end
            ST_FIND_RD, ST_INS_RD:
            begin
                slot_en = 1'b1;
            end
            ST_SH_RD:
            begin
                slot_en   = 1'b1;
                slot_addr = scan_reg;
            end
            ST_DEL_WR, ST_SH_MV:
            begin
                slot_en   = 1'b1;
                slot_we   = 1'b1;
                slot_addr = gap_reg;
            end
            ST_SH_CHK:
            begin
                slot_en    = sh_move;
                slot_we    = sh_move;
                slot_addr  = gap_reg;
                slot_wdata = slot_rdata;
            end
            ST_Q_RD:
            begin
                q_en = 1'b1;
            end
            ST_INS_CHK:
            begin
                slot_en    = (slot_rdata == '0);
                slot_we    = (slot_rdata == '0);
                slot_wdata = key_reg;
                q_en       = (slot_rdata == '0);
                q_we       = (slot_rdata == '0);
                q_addr     = tail_reg;
            end
            default:
            begin
            end
        endcase
    end

    dhsf_ram #(.ADDR_W(SLOT_W), .DATA_W(KEY_BITS)) u_slot_ram (
        .clk   (clk),
        .en    (slot_en),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    dhsf_ram #(.ADDR_W(QUEUE_LOG2), .DATA_W(KEY_BITS)) u_order_ram (
        .clk   (clk),
        .en    (q_en),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (key_reg),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            live_reg      <= '0;
            ins_pend_reg  <= 1'b0;
            res_pend_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            lg_cfg_reg    <= RST_SLOT_LOG2;
            cap_cfg_reg   <= RST_CAPACITY;
            present_reg   <= 1'b0;
            stored_reg    <= 1'b0;
            evicted_reg   <= 1'b0;
            recovered_reg <= 1'b0;
            ctx_reg       <= 1'b0;
        end
        else
        begin
            if (resp_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            // register write: store new value and empty the set
            if (cfg_wr)
            begin
                if (paddr[2] == REG_CAPACITY)
                begin
                    cap_cfg_reg <= pwdata[ENTRY_W-1:0];
                end
                else
                begin
                    lg_cfg_reg <= pwdata[LG_CFG_W-1:0];
                end
                clr_reg   <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
                live_reg  <= '0;
                state_reg <= ST_CLEAR;
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:
                    begin
                        clr_reg <= clr_reg + SLOT_W'(1);
                        if (clr_reg == {SLOT_W{1'b1}})
                        begin
                            if (ins_pend_reg)
                            begin
                                ins_pend_reg <= 1'b0;
                                probe_reg    <= home_of(key_reg, mask);
                                state_reg    <= ST_INS_RD;
                            end
                            else if (res_pend_reg)
                            begin
                                res_pend_reg <= 1'b0;
                                state_reg    <= ST_RESP;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                    ST_IDLE:
                    begin
                        if (s_tvalid)
                        begin
                            op_reg        <= s_tuser;
                            key_reg       <= s_tdata[KEY_BITS-1:0];
                            tgt_reg       <= s_tdata[KEY_BITS-1:0];
                            probe_reg     <= home_of(s_tdata[KEY_BITS-1:0], mask);
                            cnt_reg       <= '0;
                            ctx_reg       <= 1'b0;
                            present_reg   <= 1'b0;
                            stored_reg    <= 1'b0;
                            evicted_reg   <= 1'b0;
                            recovered_reg <= 1'b0;
                            case (s_tuser)
                                OP_CLEAR:
                                begin
                                    clr_reg      <= '0;
                                    head_reg     <= '0;
                                    tail_reg     <= '0;
                                    live_reg     <= '0;
                                    res_pend_reg <= 1'b1;
                                    state_reg    <= ST_CLEAR;
                                end
                                OP_LOOKUP, OP_REMEMBER:
                                begin
                                    state_reg <= (s_tdata[KEY_BITS-1:0] == '0) ? ST_RESP
                                                 : ST_FIND_RD;
                                end
                                default:
                                begin
                                    state_reg <= ST_RESP;
                                end
                            endcase
                        end
                    end
                    ST_FIND_RD:
                    begin
                        state_reg <= ST_FIND_CHK;
                    end
                    ST_FIND_CHK:
                    begin
                        if (slot_rdata == tgt_reg)
                        begin
                            if (ctx_reg)
                            begin
                                gap_reg   <= probe_reg;
                                state_reg <= ST_DEL_WR;
                            end
                            else
                            begin
                                present_reg <= 1'b1;
                                state_reg   <= ST_RESP;
                            end
                        end
                        else if ((slot_rdata == '0) || (cnt_reg == n_slots - CNT_W'(1)))
                        begin
                            if (ctx_reg)
                            begin
                                // oldest key already gone: try the next one, or empty the set after cap tries
                                tries_reg <= tries_inc;
                                if (tries_inc == cap)
                                begin
                                    recovered_reg <= 1'b1;
                                    ins_pend_reg  <= 1'b1;
                                    clr_reg       <= '0;
                                    head_reg      <= '0;
                                    tail_reg      <= '0;
                                    live_reg      <= '0;
                                    state_reg     <= ST_CLEAR;
                                end
                                else
                                begin
                                    state_reg <= ST_Q_RD;
                                end
                            end
                            else if ((op_reg == OP_REMEMBER) && (cap != '0))
                            begin
                                if (live_reg >= cap)
                                begin
                                    tries_reg <= '0;
                                    state_reg <= ST_Q_RD;
                                end
                                else
                                begin
                                    probe_reg <= home_of(key_reg, mask);
                                    state_reg <= ST_INS_RD;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_RESP;
                            end
                        end
                        else
                        begin
                            probe_reg <= (probe_reg + SLOT_W'(1)) & mask;
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= ST_FIND_RD;
                        end
                    end
                    ST_Q_RD:
                    begin
                        state_reg <= ST_Q_CHK;
                    end
                    ST_Q_CHK:
                    begin
                        if (q_rdata == '0)
                        begin
                            tries_reg <= tries_inc;
                            if (tries_inc == cap)
                            begin
                                recovered_reg <= 1'b1;
                                ins_pend_reg  <= 1'b1;
                                clr_reg       <= '0;
                                head_reg      <= '0;
                                tail_reg      <= '0;
                                live_reg      <= '0;
                                state_reg     <= ST_CLEAR;
                            end
                            else
                            begin
                                head_reg  <= head_inc;
                                state_reg <= ST_Q_RD;
                            end
                        end
                        else
                        begin
                            head_reg  <= head_inc;
                            tgt_reg   <= q_rdata;
                            probe_reg <= home_of(q_rdata, mask);
                            cnt_reg   <= '0;
                            ctx_reg   <= 1'b1;
                            state_reg <= ST_FIND_RD;
                        end
                    end
                    ST_DEL_WR:
                    begin
                        scan_reg  <= (gap_reg + SLOT_W'(1)) & mask;
                        cnt_reg   <= '0;
                        state_reg <= ST_SH_RD;
                    end
                    ST_SH_RD:
                    begin
                        state_reg <= ST_SH_CHK;
                    end
                    ST_SH_CHK:
                    begin
                        if (sh_stop)
                        begin
                            if (live_reg != '0)
                            begin
                                live_reg <= live_reg - ENTRY_W'(1);
                            end
                            evicted_reg <= 1'b1;
                            probe_reg   <= home_of(key_reg, mask);
                            state_reg   <= ST_INS_RD;
                        end
                        else
                        begin
                            scan_reg <= (scan_reg + SLOT_W'(1)) & mask;
                            cnt_reg  <= cnt_reg + CNT_W'(1);
                            if (sh_move)
                            begin
                                gap_reg   <= scan_reg;
                                state_reg <= ST_SH_MV;
                            end
                            else
                            begin
                                state_reg <= ST_SH_RD;
                            end
                        end
                    end
                    ST_SH_MV:
                    begin
                        state_reg <= ST_SH_RD;
                    end
                    ST_INS_RD:
                    begin
                        state_reg <= ST_INS_CHK;
                    end
                    ST_INS_CHK:
                    begin
                        if (slot_rdata == '0)
                        begin
                            tail_reg   <= tail_inc;
                            live_reg   <= live_reg + ENTRY_W'(1);
                            stored_reg <= 1'b1;
                            state_reg  <= ST_RESP;
                        end
                        else
                        begin
                            probe_reg <= (probe_reg + SLOT_W'(1)) & mask;
                            state_reg <= ST_INS_RD;
                        end
                    end
                    ST_RESP:
                    begin
                        if (resp_fire)
                        begin
                            m_tdata_reg <= {2'b00, live_reg, recovered_reg, evicted_reg,
                                            stored_reg, present_reg};
                            state_reg   <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    `DHSF_ASSERT_IMP(a_sweep_blocks, state_reg == ST_CLEAR, !s_tready, "request taken during sweep")
    `DHSF_ASSERT_IMP(a_store_fresh, m_tvalid && m_tdata[1], !m_tdata[0], "stored a present key")
    `DHSF_ASSERT_IMP(a_evict_excl, m_tvalid && m_tdata[2], !m_tdata[3], "evict and recover")
    `DHSF_ASSERT_IMP(a_store_count, m_tvalid && m_tdata[1], m_tdata[13:4] != 10'd0, "stored, zero count")
    `DHSF_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready && !cfg_wr, state_reg != ST_IDLE, "idle after accept")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dhsf_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         WDOG_LIMIT = 40000;
    localparam int         SLOT_MAX   = 1 << DEF_MAX_SLOTS_LOG2;
    localparam int         QUEUE_LEN  = 1 << QUEUE_LOG2;

    // One response, laid out as in m_tdata[13:0]
    typedef struct packed {
        logic [ENTRY_W-1:0] entries;
        logic               recovered;
        logic               evicted;
        logic               stored;
        logic               present;
    } verdict_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        bit          typed;
        verdict_t    verdict;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // key [31:0]
    logic [1:0]  s_tuser;   // opcode [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // present, stored, evicted, recovered, entries [13:4], zero [15:14]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dedupe_hash_set_fifo_evict_unit dut (.*);

    // Shadow of the set: slot table, insertion order, counters and registers
    logic [31:0]        shadow_slots [SLOT_MAX];
    logic [31:0]        insert_order [QUEUE_LEN];
    int unsigned        order_head;
    int unsigned        order_tail;
    int unsigned        live_keys;
    logic [3:0]         slot_lg_reg;
    logic [ENTRY_W-1:0] capacity_reg;

    verdict_t    pending_verdicts [$];
    int          mismatches;
    int          idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic [31:0] key_pool [16];

    function automatic int unsigned slot_total();
        int unsigned lg;
        lg = slot_lg_reg;
        if (lg < 1) lg = 1;
        if (lg > DEF_MAX_SLOTS_LOG2) lg = DEF_MAX_SLOTS_LOG2;
        return 1 << lg;
    endfunction

    function automatic int unsigned capacity_limit();
        int unsigned c;
        c = capacity_reg;
        if (c >= slot_total()) c = slot_total() - 1;
        if (c >= QUEUE_LEN) c = QUEUE_LEN - 1;
        return c;
    endfunction

    // Home slot: byte 3 low, byte 2 high, masked to the table
    function automatic int unsigned home_of(logic [31:0] k, int unsigned mask);
        return {k[23:16], k[31:24]} & mask;
    endfunction

    function automatic void empty_set();
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        order_head = 0;
        order_tail = 0;
        live_keys  = 0;
    endfunction

    function automatic int locate(logic [31:0] k);
        int unsigned n, mask, s;
        n    = slot_total();
        mask = n - 1;
        s    = home_of(k, mask);
        if (k == 0) return -1;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (shadow_slots[s] == 0) return -1;
            if (shadow_slots[s] == k) return s;
            s = (s + 1) & mask;
        end
        return -1;
    endfunction

    // Backward-shift delete: pull later chain members into the hole
    function automatic void remove_at(int unsigned hole);
        int unsigned n, mask, gap, scan, nat, dg, ds;
        n    = slot_total();
        mask = n - 1;
        gap  = hole & mask;
        scan = (gap + 1) & mask;
        shadow_slots[gap] = '0;
        for (int unsigned i = 0; i < n && shadow_slots[scan] != 0; i++)
        begin
            nat = home_of(shadow_slots[scan], mask);
            dg  = (gap - nat + n) & mask;
            ds  = (scan - nat + n) & mask;
            if (dg <= ds)
            begin
                shadow_slots[gap]  = shadow_slots[scan];
                shadow_slots[scan] = '0;
                gap = scan;
            end
            scan = (scan + 1) & mask;
        end
    endfunction

    function automatic verdict_t apply_request(logic [1:0] op, logic [31:0] k);
        verdict_t    v;
        int unsigned cap, n, mask, s;
        logic [31:0] old;
        int          at;
        v = '0;
        if (op == OP_LOOKUP)
        begin
            v.present = locate(k) >= 0;
        end
        else if (op == OP_REMEMBER)
        begin
            cap       = capacity_limit();
            v.present = locate(k) >= 0;
            if (k != 0 && cap != 0 && !v.present)
            begin
                n    = slot_total();
                mask = n - 1;
                if (live_keys >= cap)
                begin
                    for (int unsigned t = 0; t < cap && !v.evicted; t++)
                    begin
                        old        = insert_order[order_head % QUEUE_LEN];
                        order_head = (order_head + 1) % cap;
                        if (old != 0)
                        begin
                            at = locate(old);
                            if (at >= 0)
                            begin
                                remove_at(at);
                                if (live_keys > 0) live_keys--;
                                v.evicted = 1'b1;
                            end
                        end
                    end
                    if (!v.evicted)
                    begin
                        empty_set();
                        v.recovered = 1'b1;
                    end
                end
                s = home_of(k, mask);
                for (int unsigned i = 0; i < n && shadow_slots[s] != 0; i++) s = (s + 1) & mask;
                if (shadow_slots[s] == 0)
                begin
                    shadow_slots[s] = k;
                    insert_order[order_tail % QUEUE_LEN] = k;
                    order_tail = (order_tail + 1) % cap;
                    live_keys  = (live_keys + 1) & 10'h3FF;
                    v.stored   = 1'b1;
                end
            end
        end
        else if (op == OP_CLEAR)
        begin
            empty_set();
        end
        v.entries = live_keys[ENTRY_W-1:0];
        return v;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive one request; hold it until the block takes it, then log its verdict
    task automatic send_request(logic [1:0] op, logic [31:0] k, bit typed, verdict_t typed_v);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = k;
        do @(posedge clk); while (!s_tready);
        v = apply_request(op, k);
        pending_verdicts.push_back(typed ? typed_v : v);
        @(negedge clk);
    endtask

    // Drain outstanding responses, then idle before returning
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == 3'd0) slot_lg_reg = value[3:0];
        else capacity_reg = value[ENTRY_W-1:0];
        empty_set();
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return key_pool[$urandom_range(15)];
        if (r < 92) return $urandom;
        if (r < 96) return '0;
        return '1;
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 52) return OP_REMEMBER;
        if (r < 93) return OP_LOOKUP;
        if (r < 96) return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    // Receiver: stall at the configured rate, updated at the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted response with the oldest pending verdict
    always @(posedge clk)
    begin
        verdict_t exp_v;
        verdict_t got_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_v = m_tdata[13:0];
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got_v);
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (got_v.present !== exp_v.present || got_v.stored !== exp_v.stored ||
                    got_v.evicted !== exp_v.evicted || got_v.recovered !== exp_v.recovered ||
                    got_v.entries !== exp_v.entries || m_tdata[15:14] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p (pad %b)",
                                 exp_v, got_v, m_tdata[15:14]);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [] = '{
            '{OP_LOOKUP,   32'h0000_0000, 1'b1, {10'd0, 4'b0000}},
            '{OP_REMEMBER, 32'h0000_0000, 1'b1, {10'd0, 4'b0000}},
            '{OP_REMEMBER, 32'hFFFF_FFFF, 1'b1, {10'd1, 4'b0010}},
            '{OP_REMEMBER, 32'hFFFF_FFFF, 1'b1, {10'd1, 4'b0001}},
            '{OP_LOOKUP,   32'hFFFF_FFFF, 1'b1, {10'd1, 4'b0001}},
            '{OP_UNUSED,   32'hFFFF_FFFF, 1'b1, {10'd1, 4'b0000}},
            '{OP_REMEMBER, 32'h0000_0001, 1'b1, {10'd2, 4'b0010}},
            '{OP_REMEMBER, 32'h0000_0002, 1'b1, {10'd3, 4'b0010}},
            '{OP_REMEMBER, 32'h0001_0000, 1'b0, '0},
            '{OP_LOOKUP,   32'h0000_0002, 1'b0, '0},
            '{OP_REMEMBER, 32'h8000_0000, 1'b0, '0},
            '{OP_LOOKUP,   32'h1234_5678, 1'b0, '0},
            '{OP_LOOKUP,   32'h0000_0001, 1'b0, '0},
            '{OP_CLEAR,    32'h0000_0001, 1'b1, {10'd0, 4'b0000}},
            '{OP_LOOKUP,   32'h0000_0001, 1'b1, {10'd0, 4'b0000}}
        };
        // slot_count_log2 / entry_capacity per phase, extremes included
        int unsigned phase_lg  [8] = '{2, 1, 4, 0, 15, 5, 3, 10};
        int unsigned phase_cap [8] = '{3, 1, 20, 1, 1023, 0, 7, 512};

        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_LOOKUP;
        m_tready       = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        slot_lg_reg    = RST_SLOT_LOG2;
        capacity_reg   = RST_CAPACITY;
        foreach (insert_order[i]) insert_order[i] = '0;
        empty_set();

        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].verdict);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_register(3'd0, phase_lg[p]);
            write_register(3'd4, phase_cap[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
            for (int n = 0; n < 60; n++)
            begin
                send_request(pick_op(), pick_key(), 1'b0, '0);
                // hold off mid-phase once until the block has answered everything
                if (p == 2 && n == 30) wait_drained();
            end
            wait_drained();
        end

        repeat (200) @(negedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
